FILE: design/afs_pkg.sv
// afs_pkg: shared types, constants and control store for the feature smoother
`default_nettype none

package afs_pkg;

  // fixed field widths
  localparam int unsigned VAL_W = 16;
  localparam int unsigned HZ_W  = 15;
  localparam int unsigned CFG_W = 2;

  // centroid mapping constants
  localparam logic [HZ_W-1:0] HZ_LOW   = 15'd200;
  localparam logic [HZ_W-1:0] HZ_HIGH  = 15'd8000;
  localparam logic [17:0]     HZ_SCALE = 18'd8604;
  localparam int unsigned     HZ_SHIFT = 10;

  // shared multiplier: signed 17-bit difference times 18-bit positive factor
  localparam int unsigned MUL_A_W = VAL_W + 1;
  localparam int unsigned MUL_B_W = VAL_W + 2;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // control store size
  localparam int unsigned PROG_LEN = 7;
  localparam int unsigned PC_W     = 3;

  // configuration register indexes
  typedef enum logic [CFG_W-1:0] {
    CFG_SMOOTH_GAIN = 2'd0,
    CFG_ATTACK_GAIN = 2'd1,
    CFG_DECAY_GAIN  = 2'd2
  } cfg_idx_e;

  // multiplier operand select
  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_MAP  = 3'd1,
    MUL_LVL  = 3'd2,
    MUL_CEN  = 3'd3,
    MUL_ONS  = 3'd4,
    MUL_BAS  = 3'd5
  } mul_sel_e;

  // register update select
  typedef enum logic [2:0] {
    UPD_NONE = 3'd0,
    UPD_MAP  = 3'd1,
    UPD_LVL  = 3'd2,
    UPD_CEN  = 3'd3,
    UPD_ONS  = 3'd4,
    UPD_BAS  = 3'd5
  } upd_sel_e;

  // sequencing of the step counter
  typedef enum logic {
    JMP_NEXT = 1'b0,
    JMP_END  = 1'b1
  } jmp_e;

  // one control word
  typedef struct packed {
    mul_sel_e mul;
    upd_sel_e upd;
    logic     load_out;
    jmp_e     jmp;
  } ctrl_t;

  // control store: multiply of one channel overlaps the update of the previous
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{mul: MUL_NONE, upd: UPD_NONE, load_out: 1'b0, jmp: JMP_NEXT};
    case (pc)
      3'd0: w = '{mul: MUL_MAP,  upd: UPD_NONE, load_out: 1'b0, jmp: JMP_NEXT};
      3'd1: w = '{mul: MUL_LVL,  upd: UPD_MAP,  load_out: 1'b0, jmp: JMP_NEXT};
      3'd2: w = '{mul: MUL_CEN,  upd: UPD_LVL,  load_out: 1'b0, jmp: JMP_NEXT};
      3'd3: w = '{mul: MUL_ONS,  upd: UPD_CEN,  load_out: 1'b0, jmp: JMP_NEXT};
      3'd4: w = '{mul: MUL_BAS,  upd: UPD_ONS,  load_out: 1'b0, jmp: JMP_NEXT};
      3'd5: w = '{mul: MUL_NONE, upd: UPD_BAS,  load_out: 1'b0, jmp: JMP_NEXT};
      3'd6: w = '{mul: MUL_NONE, upd: UPD_NONE, load_out: 1'b1, jmp: JMP_END};
      default: w = '{mul: MUL_NONE, upd: UPD_NONE, load_out: 1'b0, jmp: JMP_END};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: design/audio_feature_smoother.sv
// audio_feature_smoother: one-pole smoothing of four audio features per frame
`default_nettype none

// Smooths level, centroid, onset and bass of each feature frame with one-pole
// averages (s += gain*(x-s) >>> FRAC_BITS, saturated to 0..65535); the centroid
// is clamped to 200..8000 Hz and mapped to Q0.16 first, and onset uses the
// attack gain when rising and the decay gain otherwise. A small control store
// of seven steps drives one shared 17x18 multiplier; the last step holds while
// the result register is still full and not being taken. One frame is
// processed at a time, and since the ready goes high only in the cycle after
// the last step, a new request is not taken until the previous frame is done.
// Gain registers may be written at any time the block is idle.
module audio_feature_smoother #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration writes
  input  wire                          cfg_we_i,
  input  wire  [afs_pkg::CFG_W-1:0]    cfg_idx_i,
  input  wire  [afs_pkg::VAL_W-1:0]    cfg_data_i,
  // frame request
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [afs_pkg::VAL_W-1:0]    level_i,
  input  wire  [afs_pkg::HZ_W-1:0]     centroid_hz_i,
  input  wire  [afs_pkg::VAL_W-1:0]    onset_i,
  input  wire  [afs_pkg::VAL_W-1:0]    bass_i,
  // result request
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic [afs_pkg::VAL_W-1:0]    smooth_level_o,
  output logic [afs_pkg::VAL_W-1:0]    smooth_centroid_o,
  output logic [afs_pkg::VAL_W-1:0]    smooth_onset_o,
  output logic [afs_pkg::VAL_W-1:0]    smooth_bass_o
);
  import afs_pkg::*;

  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  // gain registers
  logic [VAL_W-1:0] smooth_gain_q, attack_gain_q, decay_gain_q;

  // sequencer state
  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  ctrl_t           ctrl;

  // sampled frame
  logic [VAL_W-1:0] level_q, onset_q, bass_q;
  logic [HZ_W-1:0]  hz_q;

  // averages and mapped centroid
  logic [VAL_W-1:0] level_avg_q, centroid_avg_q, onset_avg_q, bass_avg_q;
  logic [VAL_W-1:0] cen_map_q;

  // datapath
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic [HZ_W-1:0]           hz_clamped;
  logic [HZ_W-1:0]           hz_off;
  logic [VAL_W-1:0]          mul_x, mul_s, mul_g, upd_s;
  logic signed [PROD_W-1:0]  delta, sum;
  logic [VAL_W-1:0]          upd_val, map_val;

  // handshakes
  logic in_fire, out_free, step_done;

  // out_valid_q and payload
  logic             out_valid_q;
  logic [VAL_W-1:0] out_lvl_q, out_cen_q, out_ons_q, out_bas_q;

  assign ctrl       = ucode(pc_q);
  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && !busy_q;
  assign out_free   = !out_valid_q || out_ready_i;
  assign step_done  = busy_q && (ctrl.jmp == JMP_END) && out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_gain_q <= 16'd6554;
      attack_gain_q <= 16'd32768;
      decay_gain_q  <= 16'd3277;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SMOOTH_GAIN: smooth_gain_q <= cfg_data_i;
        CFG_ATTACK_GAIN: attack_gain_q <= cfg_data_i;
        CFG_DECAY_GAIN:  decay_gain_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // step counter with end-of-program hold while the result register is full
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (in_fire) begin
      busy_d = 1'b1;
      pc_d   = '0;
    end else if (busy_q) begin
      case (ctrl.jmp)
        JMP_NEXT: pc_d = pc_q + 1'b1;
        JMP_END: begin
          if (out_free) begin
            busy_d = 1'b0;
            pc_d   = '0;
          end
        end
        default: pc_d = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  // frame capture
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      level_q <= level_i;
      hz_q    <= centroid_hz_i;
      onset_q <= onset_i;
      bass_q  <= bass_i;
    end
  end

  // centroid clamp and offset
  always_comb begin
    hz_clamped = hz_q;
    if (hz_q < HZ_LOW) begin
      hz_clamped = HZ_LOW;
    end else if (hz_q > HZ_HIGH) begin
      hz_clamped = HZ_HIGH;
    end
    hz_off = hz_clamped - HZ_LOW;
  end

  // multiplier operand selection
  always_comb begin
    mul_x = '0;
    mul_s = '0;
    mul_g = smooth_gain_q;
    case (ctrl.mul)
      MUL_LVL: begin
        mul_x = level_q;
        mul_s = level_avg_q;
      end
      MUL_CEN: begin
        mul_x = cen_map_q;
        mul_s = centroid_avg_q;
      end
      MUL_ONS: begin
        mul_x = onset_q;
        mul_s = onset_avg_q;
        mul_g = (onset_q > onset_avg_q) ? attack_gain_q : decay_gain_q;
      end
      MUL_BAS: begin
        mul_x = bass_q;
        mul_s = bass_avg_q;
      end
      default: ;
    endcase
    if (ctrl.mul == MUL_MAP) begin
      mul_a = $signed({{(MUL_A_W-HZ_W){1'b0}}, hz_off});
      mul_b = $signed(HZ_SCALE);
    end else begin
      mul_a = $signed({1'b0, mul_x}) - $signed({1'b0, mul_s});
      mul_b = $signed({{(MUL_B_W-VAL_W){1'b0}}, mul_g});
    end
    prod_d = mul_a * mul_b;
  end

  // product register
  always_ff @(posedge clk_i) begin
    if (busy_q && ctrl.mul != MUL_NONE) begin
      prod_q <= prod_d;
    end
  end

  // average update: scale the product, add, saturate
  always_comb begin
    case (ctrl.upd)
      UPD_LVL: upd_s = level_avg_q;
      UPD_CEN: upd_s = centroid_avg_q;
      UPD_ONS: upd_s = onset_avg_q;
      UPD_BAS: upd_s = bass_avg_q;
      default: upd_s = '0;
    endcase
    delta = prod_q >>> FRAC_BITS;
    sum   = $signed({{(PROD_W-VAL_W){1'b0}}, upd_s}) + delta;
    if (sum[PROD_W-1]) begin
      upd_val = '0;
    end else if (|sum[PROD_W-2:VAL_W]) begin
      upd_val = VAL_MAX;
    end else begin
      upd_val = sum[VAL_W-1:0];
    end
    // mapped centroid saturates at full scale
    if (prod_q[HZ_SHIFT+VAL_W]) begin
      map_val = VAL_MAX;
    end else begin
      map_val = prod_q[HZ_SHIFT+VAL_W-1:HZ_SHIFT];
    end
  end

  // averages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_avg_q    <= '0;
      centroid_avg_q <= '0;
      onset_avg_q    <= '0;
      bass_avg_q     <= '0;
    end else if (busy_q) begin
      case (ctrl.upd)
        UPD_LVL: level_avg_q    <= upd_val;
        UPD_CEN: centroid_avg_q <= upd_val;
        UPD_ONS: onset_avg_q    <= upd_val;
        UPD_BAS: bass_avg_q     <= upd_val;
        default: ;
      endcase
    end
  end

  // mapped centroid
  always_ff @(posedge clk_i) begin
    if (busy_q && ctrl.upd == UPD_MAP) begin
      cen_map_q <= map_val;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_done && ctrl.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_done && ctrl.load_out) begin
      out_lvl_q <= level_avg_q;
      out_cen_q <= centroid_avg_q;
      out_ons_q <= onset_avg_q;
      out_bas_q <= bass_avg_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign smooth_level_o    = out_lvl_q;
  assign smooth_centroid_o = out_cen_q;
  assign smooth_onset_o    = out_ons_q;
  assign smooth_bass_o     = out_bas_q;

endmodule

`default_nettype wire
